/* src/bsrch_pkg.sv */
package bsrch_pkg;

    localparam int unsigned POS_W     = 7;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 8;

    // Slave tdata layout, lowest bit first.
    localparam int unsigned S_POS_LSB   = 0;
    localparam int unsigned S_VALUE_LSB = S_POS_LSB + POS_W;
    localparam int unsigned S_KEY_LSB   = S_VALUE_LSB + KEY_W;

    // Master tdata layout, lowest bit first.
    localparam int unsigned M_FOUND_BIT = 0;
    localparam int unsigned M_POS_LSB   = 1;

    // Values of the action flag carried in s_axis_tuser.
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        STEP_IDLE    = 2'd0,
        STEP_PROBE   = 2'd1,
        STEP_COMPARE = 2'd2,
        STEP_EMIT    = 2'd3
    } t_step;

    typedef enum logic [2:0] {
        COND_SEQ     = 3'd0,
        COND_NOT_GO  = 3'd1,
        COND_EMPTY   = 3'd2,
        COND_NOT_HIT = 3'd3,
        COND_BUSY    = 3'd4
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  start;
        logic  probe;
        logic  cmp;
        logic  emit;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic go;
        logic empty;
        logic hit;
        logic busy;
    } t_status;

    // Microprogram. When the jump condition holds the sequencer goes to the
    // target step, otherwise to the next step (the last step wraps to idle).
    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = '{accept: 1'b0, start: 1'b0, probe: 1'b0, cmp: 1'b0, emit: 1'b0,
              cond: COND_SEQ, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.start  = 1'b1;
                w.cond   = COND_NOT_GO;
                w.target = STEP_IDLE;
            end
            STEP_PROBE: begin
                w.probe  = 1'b1;
                w.cond   = COND_EMPTY;
                w.target = STEP_EMIT;
            end
            STEP_COMPARE: begin
                w.cmp    = 1'b1;
                w.cond   = COND_NOT_HIT;
                w.target = STEP_PROBE;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_BUSY;
                w.target = STEP_EMIT;
            end
            default: begin
                w.cond   = COND_SEQ;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* src/bsrch_seq.sv */
module bsrch_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsrch_pkg::t_status i_status,
    output bsrch_pkg::t_uword  o_uword
);
    import bsrch_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_jump;

    always_comb begin
        w_uword = ucode_rom(r_step);
    end

    always_comb begin
        case (w_uword.cond)
            COND_SEQ:     w_jump = 1'b0;
            COND_NOT_GO:  w_jump = ~i_status.go;
            COND_EMPTY:   w_jump = i_status.empty;
            COND_NOT_HIT: w_jump = ~i_status.hit;
            COND_BUSY:    w_jump = i_status.busy;
            default:      w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_uword.target : t_step'(r_step + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = w_uword;

endmodule

/* src/bsrch_dp.sv */
module bsrch_dp #(
    parameter int unsigned TABLE_DEPTH = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bsrch_pkg::t_uword            i_uword,
    output bsrch_pkg::t_status           o_status,
    input  logic                         i_cfg_we,
    input  logic [bsrch_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_action,
    input  logic [bsrch_pkg::POS_W-1:0]  i_entry_position,
    input  logic signed [bsrch_pkg::KEY_W-1:0] i_entry_value,
    input  logic signed [bsrch_pkg::KEY_W-1:0] i_search_key,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found,
    output logic [bsrch_pkg::POS_W-1:0]  o_match_position
);
    import bsrch_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);

    logic [KEY_W-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0]        r_entry_count;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_rdata;
    logic [POS_W:0]          r_low;
    logic [POS_W-1:0]        r_high;
    logic [POS_W-1:0]        r_mid;
    logic                    r_found;
    logic [POS_W-1:0]        r_pos;
    logic                    r_ovalid;
    logic                    r_ofound;
    logic [POS_W-1:0]        r_opos;

    logic             w_fire;
    logic             w_wr;
    logic             w_go;
    logic [CNT_W-1:0] w_count_sat;
    logic [POS_W-1:0] w_mid;
    logic             w_empty;
    logic             w_hit;
    logic             w_less;
    logic             w_busy;
    logic             w_load;

    assign w_fire = i_in_valid & i_uword.accept;
    assign w_wr   = w_fire & (i_action == ACT_WRITE)
                  & (32'(i_entry_position) < TABLE_DEPTH);
    assign w_go   = w_fire & (i_action == ACT_SEARCH) & i_uword.start;

    // Positions past the end of the memory are never probed.
    assign w_count_sat = (32'(r_entry_count) > TABLE_DEPTH - 1)
                       ? CNT_W'(TABLE_DEPTH - 1) : r_entry_count;

    assign w_mid   = POS_W'((9'(r_low) + 9'(r_high)) >> 1);
    assign w_empty = r_low > {1'b0, r_high};
    assign w_hit   = r_key == r_rdata;
    assign w_less  = r_key < r_rdata;
    assign w_busy  = r_ovalid & ~i_out_ready;
    assign w_load  = i_uword.emit & ~w_busy;

    assign o_status = '{go: w_go, empty: w_empty, hit: w_hit, busy: w_busy};

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[AW'(i_entry_position)] <= i_entry_value;
        end
        r_rdata <= mem[AW'(w_mid)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_key   <= i_search_key;
            r_low   <= (POS_W + 1)'(1);
            r_high  <= w_count_sat;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else if (i_uword.cmp) begin
            if (w_hit) begin
                r_found <= 1'b1;
                r_pos   <= r_mid;
            end else if (w_less) begin
                r_high <= r_mid - POS_W'(1);
            end else begin
                r_low <= {1'b0, r_mid} + (POS_W + 1)'(1);
            end
        end
        if (i_uword.probe) begin
            r_mid <= w_mid;
        end
    end

    // Output register: a finished result waits here while a new item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ofound <= r_found;
            r_opos   <= r_pos;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_found          = r_ofound;
    assign o_match_position = r_opos;

endmodule

/* src/sorted_table_binary_search_top.sv */
// Sorted-table binary search. The block holds a table of signed 32-bit keys
// at positions 1 to entry_count, which the user keeps in ascending order.
// An input beat with tuser = 0 writes entry_value at entry_position and gives
// no output beat and leaves the block idle. An input beat with tuser = 1 looks
// up search_key by bisection and gives one output beat carrying found and the
// matching position, or found = 0 and position 0 when the key is absent or
// the table is empty. Each probe reads the table memory at the midpoint and
// then compares the word read with the key. The result sits in an output
// register, so the next beat is taken while an earlier result still waits.
// entry_count is written through i_cfg_we / i_cfg_wdata, by the user only
// while the block is idle; the block itself does not enforce this. The count
// is capped at TABLE_DEPTH - 1, and writes to positions at or past
// TABLE_DEPTH are dropped. Entries must be written before a search reads them.
module sorted_table_binary_search_top #(
    parameter int unsigned TABLE_DEPTH = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: entry_count.
    input  logic                             i_cfg_we,
    input  logic [bsrch_pkg::CNT_W-1:0]      i_cfg_wdata,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: entry_position [6:0], entry_value [38:7], search_key [70:39], zero [71].
    input  logic [bsrch_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: action [0] (0 write, 1 search).
    input  logic                             s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: found [0], match_position [7:1].
    output logic [bsrch_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import bsrch_pkg::*;

    t_uword           w_uword;
    t_status          w_status;
    logic             w_found;
    logic [POS_W-1:0] w_match_position;

    // The step counter walks the microprogram; the datapath acts on
    // the control word of the current step.
    bsrch_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uword  (w_uword)
    );

    bsrch_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_uword          (w_uword),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (s_axis_tvalid),
        .i_action         (s_axis_tuser),
        .i_entry_position (s_axis_tdata[S_POS_LSB +: POS_W]),
        .i_entry_value    (s_axis_tdata[S_VALUE_LSB +: KEY_W]),
        .i_search_key     (s_axis_tdata[S_KEY_LSB +: KEY_W]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_found          (w_found),
        .o_match_position (w_match_position)
    );

    // Beats are only taken in the idle step of the program.
    assign s_axis_tready = w_uword.accept;

    assign m_axis_tdata = {w_match_position, w_found};

endmodule

/* src/bsrch_chk.sv */
module bsrch_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [bsrch_pkg::CNT_W-1:0]     i_cfg_wdata,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [bsrch_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bsrch_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import bsrch_pkg::*;

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped before it was taken");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // A miss reports position zero; a hit never does.
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[M_FOUND_BIT]
        |-> m_axis_tdata[M_POS_LSB +: POS_W] == '0)
        else $error("miss reported with a nonzero position");

    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[M_FOUND_BIT]
        |-> m_axis_tdata[M_POS_LSB +: POS_W] != '0)
        else $error("hit reported at position zero");

    // Once a search is taken the block is busy for at least the next cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_SEARCH
        |=> !s_axis_tready)
        else $error("new beat taken right after a search started");

endmodule

bind sorted_table_binary_search_top bsrch_chk u_bsrch_chk (.*);
